@@ rtl/pfenc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair encryptor package
// Shared types, constants and letter-coding helpers for the Playfair block.
// ----------------------------------------------------------------------------
package pfenc_pkg;

   localparam int GRID_SIDE = 5;
   localparam int CELLS     = GRID_SIDE * GRID_SIDE;
   localparam int CODE_W    = $clog2(CELLS);
   localparam int FILL_W    = $clog2(CELLS + 1);
   localparam int RC_W      = $clog2(GRID_SIDE);

   // Letters are coded 0..24 for A..I, K..Z.
   typedef logic [CODE_W-1:0] code_type;
   typedef logic [FILL_W-1:0] fill_type;
   typedef logic [RC_W-1:0]   rc_type;
   typedef logic [CELLS-1:0]  used_type;

   localparam code_type LETTER_X  = code_type'(22);
   localparam code_type LAST_CELL = code_type'(CELLS - 1);
   localparam code_type CODE_J_GAP = code_type'(9);
   localparam used_type ALL_USED  = '1;

   localparam logic FUNC_KEY = 1'b0;
   localparam logic FUNC_MSG = 1'b1;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_UPPER_I = 8'h49;
   localparam logic [7:0] CHAR_UPPER_J = 8'h4A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   typedef logic [QPTR_W-1:0] qptr_type;
   typedef logic [QCNT_W-1:0] qcnt_type;

   // One classified input beat as it waits in the queue.
   typedef struct packed {
      logic     func;
      logic     is_letter;
      code_type code;
      logic     last;
   } item_type;

   function automatic item_type classify(logic func, logic [7:0] ch, logic last);
      logic [7:0] up;
      logic [7:0] diff;
      code_type   c;
      item_type   it;
      up = ch;
      if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
         up = ch - CASE_OFFSET;
      end
      it.func      = func;
      it.last      = last;
      it.is_letter = (up >= CHAR_UPPER_A) && (up <= CHAR_UPPER_Z);
      if (up == CHAR_UPPER_J) begin
         up = CHAR_UPPER_I;
      end
      diff = up - CHAR_UPPER_A;
      c    = diff[CODE_W-1:0];
      if (c > CODE_J_GAP) begin
         c = c - code_type'(1);
      end
      it.code = c;
      return it;
   endfunction

   function automatic logic [6:0] ascii_of(code_type c);
      logic [6:0] a;
      a = CHAR_UPPER_A[6:0] + 7'(c);
      if (c >= CODE_J_GAP) begin
         a = a + 7'd1;
      end
      return a;
   endfunction

   function automatic rc_type row_of(code_type p);
      rc_type r;
      r = '0;
      for (int k = 1; k < GRID_SIDE; k++) begin
         if (p >= code_type'(k * GRID_SIDE)) begin
            r = rc_type'(k);
         end
      end
      return r;
   endfunction

   function automatic code_type cell_of(rc_type r, rc_type c);
      return code_type'(r) * code_type'(GRID_SIDE) + code_type'(c);
   endfunction

   function automatic rc_type col_of(code_type p);
      code_type base;
      base = cell_of(row_of(p), rc_type'(0));
      return rc_type'(p - base);
   endfunction

   function automatic rc_type wrap_inc(rc_type v);
      return (v == rc_type'(GRID_SIDE - 1)) ? rc_type'(0) : v + rc_type'(1);
   endfunction

endpackage

@@ rtl/pfenc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair encryptor channels
// Valid/ready channels for the character input and the cipher letter output.
// ----------------------------------------------------------------------------
interface pfenc_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] char_in;
   logic       last_in;

   modport source (output valid, func, char_in, last_in, input ready);
   modport sink   (input valid, func, char_in, last_in, output ready);
endinterface

interface pfenc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] cipher_char;
   logic       last_out;

   modport source (output valid, cipher_char, last_out, input ready);
   modport sink   (input valid, cipher_char, last_out, output ready);
endinterface

@@ rtl/pfenc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair encryptor front end
// Accepts input beats, classifies each character and queues it for the engine.
// ----------------------------------------------------------------------------
module pfenc_front (
   input  logic               clock,
   input  logic               reset,
   pfenc_req_if.sink          req_ch,
   output pfenc_pkg::item_type head_item,
   output logic               head_valid,
   input  logic               head_pop
);
   import pfenc_pkg::*;

   item_type q_ff [QUEUE_DEPTH];
   qptr_type wr_ptr_ff, wr_ptr_in;
   qptr_type rd_ptr_ff, rd_ptr_in;
   qcnt_type cnt_ff, cnt_in;
   logic     push, pop;

   assign req_ch.ready = (cnt_ff != qcnt_type'(QUEUE_DEPTH));
   assign head_valid   = (cnt_ff != '0);
   assign head_item    = q_ff[rd_ptr_ff];
   assign push         = req_ch.valid && req_ch.ready;
   assign pop          = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == qptr_type'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + qptr_type'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == qptr_type'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + qptr_type'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + qcnt_type'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - qcnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= classify(req_ch.func, req_ch.char_in, req_ch.last_in);
      end
   end

endmodule

@@ rtl/pfenc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair encryptor engine
// Builds the key square and encrypts queued message letters pair by pair.
// ----------------------------------------------------------------------------
module pfenc_back (
   input  logic                clock,
   input  logic                reset,
   input  pfenc_pkg::item_type head_item,
   input  logic                head_valid,
   output logic                head_pop,
   pfenc_rsp_if.source         rsp_ch
);
   import pfenc_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CLOSE = 6'b000010,
      ST_FEED  = 6'b000100,
      ST_POS   = 6'b001000,
      ST_EMIT0 = 6'b010000,
      ST_EMIT1 = 6'b100000
   } state_type;

   // Feed slots of one message item: inserted X, the letter, the closing pad.
   typedef enum logic [3:0] {
      STG_DUP    = 4'b0001,
      STG_LETTER = 4'b0010,
      STG_PAD    = 4'b0100,
      STG_END    = 4'b1000
   } stage_type;

   state_type state_ff, state_in;
   stage_type stage_ff, stage_in;
   used_type  used_ff, used_in;
   fill_type  fill_ff, fill_in;
   logic      key_open_ff, key_open_in;
   logic      loaded_ff, loaded_in;
   logic      prev_valid_ff, prev_valid_in;
   code_type  prev_ff, prev_in;
   logic      pend_valid_ff, pend_valid_in;
   code_type  pend_ff, pend_in;
   code_type  close_idx_ff, close_idx_in;
   logic      final_ff, final_in;
   logic      out_valid_ff, out_valid_in;
   logic [6:0] out_char_ff, out_char_in;
   logic      out_last_ff, out_last_in;

   // Square storage: cell to letter, and letter to cell.
   code_type  sq_mem  [CELLS];
   code_type  pos_mem [CELLS];
   code_type  sq_rd_ff [2];
   code_type  sq_ra_ff [2];
   code_type  pos_rd_ff [2];
   code_type  pos_ra_ff [2];
   code_type  sq_val [2];
   code_type  pos_val [2];

   logic      head_key, key_start, place_req, place_new, mem_we;
   code_type  place_code;
   used_type  used_eff, used_place;
   fill_type  fill_eff, fill_place;
   logic      feed_en, feed_fin;
   code_type  feed_code;
   logic      pos_re, sq_re;
   code_type  sq_ra [2];
   rc_type    r1, c1, r2, c2;
   logic      out_free;

   assign head_key  = (head_item.func == FUNC_KEY);
   assign key_start = (state_ff == ST_IDLE) && head_valid && head_key && !key_open_ff;
   assign place_req = ((state_ff == ST_IDLE) && head_valid && head_key && head_item.is_letter)
                      || (state_ff == ST_CLOSE);
   assign place_code = (state_ff == ST_CLOSE) ? close_idx_ff : head_item.code;

   // A new key starts from an empty square in the same cycle as its first character.
   assign used_eff = key_start ? '0 : used_ff;
   assign fill_eff = key_start ? '0 : fill_ff;

   always_comb begin
      place_new  = place_req && !used_eff[place_code];
      mem_we     = place_new && (fill_eff < fill_type'(CELLS));
      used_place = used_eff;
      fill_place = fill_eff;
      if (place_req) begin
         used_place = used_eff | (used_type'(1) << place_code);
      end
      if (mem_we) begin
         fill_place = fill_eff + fill_type'(1);
      end
   end

   always_comb begin
      feed_en   = 1'b0;
      feed_code = LETTER_X;
      feed_fin  = 1'b0;
      unique case (stage_ff)
         STG_DUP: begin
            feed_en = head_item.is_letter && prev_valid_ff && (prev_ff == head_item.code);
         end
         STG_LETTER: begin
            feed_en   = head_item.is_letter;
            feed_code = head_item.code;
            feed_fin  = head_item.last;
         end
         STG_PAD: begin
            feed_en  = head_item.last && pend_valid_ff;
            feed_fin = 1'b1;
         end
         default: begin
            feed_en = 1'b0;
         end
      endcase
   end

   // Until the first key arrives the square is the plain alphabet.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         sq_val[k]  = loaded_ff ? sq_rd_ff[k]  : sq_ra_ff[k];
         pos_val[k] = loaded_ff ? pos_rd_ff[k] : pos_ra_ff[k];
      end
   end

   always_comb begin
      r1 = row_of(pos_val[0]);
      c1 = col_of(pos_val[0]);
      r2 = row_of(pos_val[1]);
      c2 = col_of(pos_val[1]);
      if (r1 == r2) begin
         sq_ra[0] = cell_of(r1, wrap_inc(c1));
         sq_ra[1] = cell_of(r2, wrap_inc(c2));
      end else if (c1 == c2) begin
         sq_ra[0] = cell_of(wrap_inc(r1), c1);
         sq_ra[1] = cell_of(wrap_inc(r2), c2);
      end else begin
         sq_ra[0] = cell_of(r1, c2);
         sq_ra[1] = cell_of(r2, c1);
      end
   end

   assign out_free = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in      = state_ff;
      stage_in      = stage_ff;
      used_in       = used_ff;
      fill_in       = fill_ff;
      key_open_in   = key_open_ff;
      loaded_in     = loaded_ff;
      prev_valid_in = prev_valid_ff;
      prev_in       = prev_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      close_idx_in  = close_idx_ff;
      final_in      = final_ff;
      head_pop      = 1'b0;
      pos_re        = 1'b0;
      sq_re         = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_char_in   = out_char_ff;
      out_last_in   = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               if (head_key) begin
                  if (key_start) begin
                     key_open_in   = 1'b1;
                     loaded_in     = 1'b1;
                     prev_valid_in = 1'b0;
                     pend_valid_in = 1'b0;
                  end
                  used_in = used_place;
                  fill_in = fill_place;
                  if (head_item.last) begin
                     close_idx_in = '0;
                     state_in     = ST_CLOSE;
                  end else begin
                     head_pop = 1'b1;
                  end
               end else if (key_open_ff) begin
                  close_idx_in = '0;
                  state_in     = ST_CLOSE;
               end else begin
                  stage_in = STG_DUP;
                  state_in = ST_FEED;
               end
            end
         end
         ST_CLOSE: begin
            // Walk the alphabet once, placing every letter not yet in the square.
            used_in = used_place;
            fill_in = fill_place;
            if (close_idx_ff == LAST_CELL) begin
               key_open_in = 1'b0;
               if (head_key) begin
                  head_pop = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  stage_in = STG_DUP;
                  state_in = ST_FEED;
               end
            end else begin
               close_idx_in = close_idx_ff + code_type'(1);
            end
         end
         ST_FEED: begin
            if (stage_ff == STG_END) begin
               if (head_item.is_letter) begin
                  prev_valid_in = 1'b1;
                  prev_in       = head_item.code;
               end
               if (head_item.last) begin
                  prev_valid_in = 1'b0;
                  pend_valid_in = 1'b0;
               end
               head_pop = 1'b1;
               state_in = ST_IDLE;
            end else if (feed_en && pend_valid_ff) begin
               pos_re        = 1'b1;
               pend_valid_in = 1'b0;
               final_in      = feed_fin;
               state_in      = ST_POS;
            end else begin
               if (feed_en) begin
                  pend_valid_in = 1'b1;
                  pend_in       = feed_code;
               end
               stage_in = stage_type'(stage_ff << 1);
            end
         end
         ST_POS: begin
            sq_re    = 1'b1;
            state_in = ST_EMIT0;
         end
         ST_EMIT0: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = ascii_of(sq_val[0]);
               out_last_in  = 1'b0;
               state_in     = ST_EMIT1;
            end
         end
         ST_EMIT1: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = ascii_of(sq_val[1]);
               out_last_in  = final_ff;
               stage_in     = stage_type'(stage_ff << 1);
               state_in     = ST_FEED;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         stage_ff      <= STG_DUP;
         used_ff       <= ALL_USED;
         fill_ff       <= '0;
         key_open_ff   <= 1'b0;
         loaded_ff     <= 1'b0;
         prev_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         close_idx_ff  <= '0;
         final_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         stage_ff      <= stage_in;
         used_ff       <= used_in;
         fill_ff       <= fill_in;
         key_open_ff   <= key_open_in;
         loaded_ff     <= loaded_in;
         prev_valid_ff <= prev_valid_in;
         pend_valid_ff <= pend_valid_in;
         close_idx_ff  <= close_idx_in;
         final_ff      <= final_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff     <= prev_in;
      pend_ff     <= pend_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sq_mem[fill_eff[CODE_W-1:0]] <= place_code;
      end
      if (sq_re) begin
         for (int k = 0; k < 2; k++) begin
            sq_rd_ff[k] <= sq_mem[sq_ra[k]];
            sq_ra_ff[k] <= sq_ra[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pos_mem[place_code] <= fill_eff[CODE_W-1:0];
      end
      if (pos_re) begin
         pos_rd_ff[0] <= pos_mem[pend_ff];
         pos_ra_ff[0] <= pend_ff;
         pos_rd_ff[1] <= pos_mem[feed_code];
         pos_ra_ff[1] <= feed_code;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.cipher_char = out_char_ff;
   assign rsp_ch.last_out    = out_last_ff;

`ifndef ASSERT_OFF
   a_cipher_letter : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_char_ff >= CHAR_UPPER_A[6:0]) && (out_char_ff <= CHAR_UPPER_Z[6:0])
                       && (out_char_ff != CHAR_UPPER_J[6:0]))
      else $error("cipher beat is not a square letter");

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= fill_type'(CELLS))
      else $error("square fill count overran the grid");

   a_close_complete : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLOSE) && (close_idx_ff == LAST_CELL)
      |=> (used_ff == ALL_USED) && (fill_ff == fill_type'(CELLS)) && !key_open_ff)
      else $error("key completion left the square partly filled");

   a_pair_consumed : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POS) |-> !pend_valid_ff)
      else $error("pending letter kept after forming a pair");
`endif

endmodule

@@ rtl/playfair_encryptor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair encryptor
// Streams key and message characters and returns Playfair cipher letters.
// ----------------------------------------------------------------------------
// Key characters (func 0) build the 5x5 square and message characters (func 1)
// come back as cipher letters, one letter per result beat, with last_out on
// the final letter of a message. A two-beat input queue lets the front end
// keep taking characters while the engine works or a result beat waits. The
// final key character, or the first message character after an unfinished
// key, adds a walk over the alphabet that fills the rest of the square. Each
// pair a message character completes takes two registered square reads, then
// two result beats, which wait while the result side stalls. The square
// memories are ready at reset and need no clearing.
module playfair_encryptor (
   input  logic        clock,
   input  logic        reset,
   pfenc_req_if.sink   req_ch,
   pfenc_rsp_if.source rsp_ch
);
   import pfenc_pkg::*;

   item_type head_item;
   logic     head_valid;
   logic     head_pop;

   pfenc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .head_item  (head_item),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   pfenc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_item  (head_item),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

@@ tb/tb_playfair_encryptor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair encryptor testbench
// Sends key and message characters over the input channel. A behavioral copy
// of the square and the pair logic predicts every cipher letter, and each
// output beat is checked in order. Both channels idle at random, and one test
// holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_playfair_encryptor;
   import pfenc_pkg::*;

   localparam int         STALL_LIMIT  = 2000;
   localparam int         DRAIN_CYCLES = 64;
   localparam int         LONG_HOLD    = 300;
   localparam int         RANDOM_ITEMS = 70;
   localparam int         MAX_REPORTS  = 100;
   localparam logic [5:0] NO_CODE      = 6'h20;
   localparam string      ALPHABET     = "ABCDEFGHIKLMNOPQRSTUVWXYZ";

   typedef struct packed {
      logic [6:0] letter;
      logic       last;
   } cipher_beat_type;

   logic clock = 1'b0;
   logic reset;

   pfenc_req_if req_ch ();
   pfenc_rsp_if rsp_ch ();

   playfair_encryptor u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Predicted square and message state.
   code_type        sq_letter [CELLS];
   code_type        letter_cell [CELLS];
   used_type        placed;
   int              fill_cnt;
   bit              key_active;
   logic [5:0]      prior_code;
   logic [5:0]      open_code;
   cipher_beat_type step_beats [$];
   cipher_beat_type cipher_q [$];

   int mismatches   = 0;
   int req_run_left = 0;
   int rsp_run_left = 0;
   bit req_no_gap   = 1'b0;
   int rsp_hold     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [5:0] letter_code(logic [7:0] ch);
      logic [7:0] up;
      int         k;
      up = ch;
      if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) up = ch - CASE_OFFSET;
      if (up < CHAR_UPPER_A || up > CHAR_UPPER_Z) return NO_CODE;
      if (up == CHAR_UPPER_J) up = CHAR_UPPER_I;
      k = int'(up - CHAR_UPPER_A);
      if (k > int'(CODE_J_GAP)) k--;
      return 6'(k);
   endfunction

   function automatic logic [6:0] letter_ascii(code_type c);
      return 7'(ALPHABET[int'(c)]);
   endfunction

   function automatic void place_letter(code_type c);
      if (placed[c]) return;
      if (fill_cnt < CELLS) begin
         sq_letter[fill_cnt] = c;
         letter_cell[c] = code_type'(fill_cnt);
         fill_cnt++;
      end
      placed[c] = 1'b1;
   endfunction

   function automatic void seal_square();
      for (int i = 0; i < CELLS; i++) place_letter(code_type'(i));
      key_active = 1'b0;
   endfunction

   // Holds the first letter of a pair; on the second one, encrypts the pair.
   function automatic void pair_in(code_type c);
      int              r1, c1, r2, c2;
      code_type        a, b;
      cipher_beat_type beat;
      if (open_code == NO_CODE) begin
         open_code = {1'b0, c};
         return;
      end
      r1 = int'(letter_cell[open_code[CODE_W-1:0]]) / GRID_SIDE;
      c1 = int'(letter_cell[open_code[CODE_W-1:0]]) % GRID_SIDE;
      r2 = int'(letter_cell[c]) / GRID_SIDE;
      c2 = int'(letter_cell[c]) % GRID_SIDE;
      open_code = NO_CODE;
      if (r1 == r2) begin
         a = sq_letter[r1 * GRID_SIDE + (c1 + 1) % GRID_SIDE];
         b = sq_letter[r2 * GRID_SIDE + (c2 + 1) % GRID_SIDE];
      end else if (c1 == c2) begin
         a = sq_letter[((r1 + 1) % GRID_SIDE) * GRID_SIDE + c1];
         b = sq_letter[((r2 + 1) % GRID_SIDE) * GRID_SIDE + c2];
      end else begin
         a = sq_letter[r1 * GRID_SIDE + c2];
         b = sq_letter[r2 * GRID_SIDE + c1];
      end
      beat.last   = 1'b0;
      beat.letter = letter_ascii(a);
      step_beats.push_back(beat);
      beat.letter = letter_ascii(b);
      step_beats.push_back(beat);
   endfunction

   function automatic void model_step(logic f, logic [7:0] ch, logic l);
      logic [5:0]      code;
      cipher_beat_type tail;
      code = letter_code(ch);
      step_beats.delete();
      if (f == FUNC_KEY) begin
         if (!key_active) begin
            placed     = '0;
            fill_cnt   = 0;
            key_active = 1'b1;
            prior_code = NO_CODE;
            open_code  = NO_CODE;
         end
         if (code != NO_CODE) place_letter(code[CODE_W-1:0]);
         if (l) seal_square();
         return;
      end
      if (key_active) seal_square();
      if (code != NO_CODE) begin
         // A doubled letter gets an X between, even across a pair boundary.
         if (prior_code == code) pair_in(LETTER_X);
         pair_in(code[CODE_W-1:0]);
         prior_code = code;
      end
      if (l) begin
         if (open_code != NO_CODE) pair_in(LETTER_X);
         if (step_beats.size() > 0) begin
            tail = step_beats.pop_back();
            tail.last = 1'b1;
            step_beats.push_back(tail);
         end
         prior_code = NO_CODE;
         open_code  = NO_CODE;
      end
      foreach (step_beats[i]) cipher_q.push_back(step_beats[i]);
   endfunction

   function automatic int draw_gap(inout int run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         run_left = $urandom_range(8, 24);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   function automatic logic [7:0] random_char();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(0, 255));
         1: return CHAR_LOWER_A + 8'($urandom_range(0, 25));
         default: return CHAR_UPPER_A + 8'($urandom_range(0, 25));
      endcase
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
      end
   endtask

   task automatic send_char(logic f, logic [7:0] ch, logic l);
      int gap;
      gap = req_no_gap ? 0 : draw_gap(req_run_left);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.func    <= f;
      req_ch.char_in <= ch;
      req_ch.last_in <= l;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      model_step(f, ch, l);
   endtask

   task automatic send_text(logic f, string s, bit close);
      for (int i = 0; i < s.len(); i++) begin
         send_char(f, s[i], close && (i == s.len() - 1));
      end
   endtask

   task automatic send_random_run(logic f, int len, bit close, inout int tally);
      logic [7:0] ch;
      logic [7:0] prev;
      logic       l;
      prev = CHAR_UPPER_A;
      for (int i = 0; i < len; i++) begin
         // Repeating the previous character now and then exercises doubled letters.
         ch = ($urandom_range(0, 3) == 0) ? prev : random_char();
         l  = close && (i == len - 1);
         send_char(f, ch, l);
         tally++;
         prev = ch;
      end
   endtask

   task automatic test_plain_square();
      // No key yet, so the plain alphabet square applies.
      send_text(FUNC_MSG, "Xx", 1'b0);
      send_char(FUNC_MSG, 8'hFF, 1'b1);
      send_text(FUNC_MSG, "AA", 1'b1);
   endtask

   task automatic test_key_build();
      send_text(FUNC_KEY, "jZ@z", 1'b0);
      send_char(FUNC_KEY, 8'h00, 1'b1);
   endtask

   task automatic test_pair_rules();
      // Same row, same column and rectangle pairs, with the letter range edges
      // and their non-letter neighbors mixed in; the final beat yields nothing.
      send_text(FUNC_MSG, "Ic[Ze`at{@", 1'b0);
      send_char(FUNC_MSG, 8'h80, 1'b1);
   endtask

   task automatic test_key_interrupts();
      // A new key drops the open half pair; the message then closes the key.
      send_char(FUNC_MSG, "M", 1'b0);
      send_text(FUNC_KEY, "QK", 1'b0);
      send_text(FUNC_MSG, "qk", 1'b1);
   endtask

   task automatic test_output_stall();
      rsp_hold   = LONG_HOLD;
      req_no_gap = 1'b1;
      send_text(FUNC_MSG, "THEQUICKBROWNFOXJUMPSOVERTHELAZYDOG", 1'b1);
      req_no_gap = 1'b0;
   endtask

   task automatic test_random_stream();
      int tally;
      int pick;
      tally = 0;
      while (tally < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            repeat ($urandom_range(1, 4)) begin
               send_char(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
               tally++;
            end
         end else if (pick == 1) begin
            send_random_run(FUNC_MSG, $urandom_range(1, 5), 1'b0, tally);
            send_random_run(FUNC_KEY, $urandom_range(1, 6), 1'b1, tally);
         end else begin
            if (pick < 6) begin
               send_random_run(FUNC_KEY, $urandom_range(1, 10), $urandom_range(0, 3) != 0,
                               tally);
            end
            send_random_run(FUNC_MSG, $urandom_range(1, 12), 1'b1, tally);
         end
      end
   endtask

   initial begin : result_sink
      int wait_cycles;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      @(negedge clock);
      forever begin
         wait_cycles = draw_gap(rsp_run_left);
         if (rsp_hold > 0) begin
            wait_cycles = rsp_hold;
            rsp_hold    = 0;
         end
         if (wait_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : cipher_check
      cipher_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (cipher_q.size() == 0) begin
            report_mismatch("unexpected cipher letter", int'(rsp_ch.cipher_char), 0);
         end else begin
            want = cipher_q.pop_front();
            if (rsp_ch.cipher_char !== want.letter) begin
               report_mismatch("cipher_char", int'(rsp_ch.cipher_char), int'(want.letter));
            end
            if (rsp_ch.last_out !== want.last) begin
               report_mismatch("last_out", int'(rsp_ch.last_out), int'(want.last));
            end
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("[playfair_encryptor] ERROR");
      $finish;
   end

   initial begin : run_tests
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.func    = FUNC_KEY;
      req_ch.char_in = 8'h00;
      req_ch.last_in = 1'b0;
      for (int i = 0; i < CELLS; i++) begin
         sq_letter[i]   = code_type'(i);
         letter_cell[i] = code_type'(i);
      end
      placed     = ALL_USED;
      fill_cnt   = 0;
      key_active = 1'b0;
      prior_code = NO_CODE;
      open_code  = NO_CODE;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_plain_square();
      test_key_build();
      test_pair_rules();
      test_key_interrupts();
      test_output_stall();
      test_random_stream();

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (cipher_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[playfair_encryptor] OK");
      end else begin
         $display("[playfair_encryptor] ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/pfenc_pkg.sv
rtl/pfenc_if.sv
rtl/pfenc_front.sv
rtl/pfenc_back.sv
rtl/playfair_encryptor.sv
tb/tb_playfair_encryptor.sv
